/* sv/gfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers of the first-fit rectangle allocator.
// Depends on nothing; every other file of the block imports it.
package gfa_pkg;

    localparam int MAX_WIDTH  = 32;
    localparam int MAX_HEIGHT = 32;

    localparam int XW        = $clog2(MAX_WIDTH);
    localparam int YW        = $clog2(MAX_HEIGHT);
    localparam int RUNW      = $clog2(MAX_HEIGHT + 1);
    localparam int CFG_W     = 6;
    localparam int CW        = CFG_W + 1;
    localparam int SIZE_W    = 6;
    localparam int POS_W     = 5;
    localparam int ROOM_W    = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0]     CFG_RESET       = 6'd32;
    localparam logic [ROOM_W-1:0]    COUNT_MAX       = 11'd2047;
    localparam logic                 REQ_CLEAR       = 1'b0;
    localparam logic                 REQ_ALLOC       = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
    } req_t;

    typedef struct packed {
        logic              placed;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [ROOM_W-1:0] room_number;
        logic              grid_full;
    } rsp_t;

    typedef struct packed {
        logic                 clear;
        logic                 wr;
        logic [YW-1:0]        idx;
        logic [MAX_WIDTH-1:0] mask;
    } grid_ctrl_t;

    typedef struct packed {
        logic          start;
        logic          step;
        logic [YW-1:0] row_y;
    } lane_ctrl_t;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_PICK = 6'b000100,
        S_MARK = 6'b001000,
        S_FULL = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    // Mask with the lowest n bits set.
    function automatic logic [MAX_WIDTH-1:0] low_mask(input logic [CW-1:0] n);
        logic [MAX_WIDTH-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

endpackage

/* sv/gfa_grid.sv */
`timescale 1ns / 1ps
// Occupancy grid storage: one row of cell bits per y, cleared at once,
// one row read and one row OR-written per cycle. Depends on gfa_pkg.
module gfa_grid (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfa_pkg::grid_ctrl_t           ctrl,
    output logic [gfa_pkg::MAX_WIDTH-1:0] row
);
    import gfa_pkg::*;

    logic [MAX_WIDTH-1:0] rows_reg  [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0] rows_next [MAX_HEIGHT];

    always_comb
    begin
        rows_next = rows_reg;
        if (ctrl.clear)
        begin
            for (int i = 0; i < MAX_HEIGHT; i++)
            begin
                rows_next[i] = '0;
            end
        end
        else if (ctrl.wr)
        begin
            rows_next[ctrl.idx] = rows_reg[ctrl.idx] | ctrl.mask;
        end
    end

    assign row = rows_reg[ctrl.idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_HEIGHT; i++)
            begin
                rows_reg[i] <= '0;
            end
        end
        else
        begin
            rows_reg <= rows_next;
        end
    end

endmodule

/* sv/gfa_lanes.sv */
`timescale 1ns / 1ps
// Window test per candidate x: tracks runs of free rows for every column
// origin while rows stream past, and picks the lowest x that fits. Uses gfa_pkg.
module gfa_lanes (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfa_pkg::lane_ctrl_t           ctrl,
    input  logic [gfa_pkg::MAX_WIDTH-1:0] row,
    input  logic [gfa_pkg::MAX_WIDTH-1:0] size_mask,
    input  logic [gfa_pkg::SIZE_W-1:0]    size_x,
    input  logic [gfa_pkg::SIZE_W-1:0]    size_y,
    input  logic [gfa_pkg::CW-1:0]        area_w,
    output logic                          pick_valid,
    output logic [gfa_pkg::XW-1:0]        pick_x,
    output logic [gfa_pkg::YW-1:0]        pick_y
);
    import gfa_pkg::*;

    logic [MAX_WIDTH-1:0] found_reg, found_next;
    logic [RUNW-1:0]      run_reg  [MAX_WIDTH];
    logic [RUNW-1:0]      run_next [MAX_WIDTH];
    logic [YW-1:0]        fy_reg   [MAX_WIDTH];
    logic [YW-1:0]        fy_next  [MAX_WIDTH];
    logic [MAX_WIDTH-1:0] lane_en;
    logic [MAX_WIDTH-1:0] lane_free;
    logic [MAX_WIDTH-1:0] lane_mask;

    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            lane_mask    = size_mask << x;
            lane_free[x] = ((row & lane_mask) == '0);
            lane_en[x]   = ((x + int'(size_x)) <= int'(area_w));
        end
    end

    always_comb
    begin
        found_next = found_reg;
        run_next   = run_reg;
        fy_next    = fy_reg;
        if (ctrl.start)
        begin
            found_next = '0;
            for (int x = 0; x < MAX_WIDTH; x++)
            begin
                run_next[x] = '0;
            end
        end
        else if (ctrl.step)
        begin
            for (int x = 0; x < MAX_WIDTH; x++)
            begin
                run_next[x] = lane_free[x] ? RUNW'(run_reg[x] + 1'b1) : '0;
                // A lane keeps the origin y of the first run of free rows that reaches the height.
                if (lane_en[x] && !found_reg[x] && lane_free[x] &&
                    (CW'(run_reg[x]) + CW'(1) == CW'(size_y)))
                begin
                    found_next[x] = 1'b1;
                    fy_next[x]    = YW'(CW'(ctrl.row_y) + CW'(1) - CW'(size_y));
                end
            end
        end
    end

    always_comb
    begin
        pick_valid = 1'b0;
        pick_x     = '0;
        pick_y     = '0;
        for (int x = MAX_WIDTH - 1; x >= 0; x--)
        begin
            if (found_reg[x])
            begin
                pick_valid = 1'b1;
                pick_x     = XW'(x);
                pick_y     = fy_reg[x];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= '0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg <= run_next;
        fy_reg  <= fy_next;
    end

endmodule

/* sv/grid_first_fit_rect_allocator_top.sv */
`timescale 1ns / 1ps
// Top level of the first-fit rectangle allocator: sequencer, configuration
// registers and result register. Uses gfa_pkg, gfa_grid and gfa_lanes.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------
//  request  | req_valid / req_stall  | req_data  (gfa_pkg::req_t)
//  result   | rsp_valid / rsp_stall  | rsp_data  (gfa_pkg::rsp_t)
//  config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An allocate request scans the H rows of the area once, picks the origin,
// writes size_y rows, then checks the H rows for the full flag. A clear
// request empties the grid and then checks the rows for the full flag.
// The grid port gives one row at a time, so each pass steps through the rows.
// Reset empties the grid at once and sets both area registers to 32.
// A new request is taken while an earlier result still waits under rsp_stall.
module grid_first_fit_rect_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  gfa_pkg::req_t                 req_data,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output gfa_pkg::rsp_t                 rsp_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [gfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gfa_pkg::CFG_W-1:0]     cfg_data
);
    import gfa_pkg::*;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     gw_reg, gw_next;
    logic [CFG_W-1:0]     gh_reg, gh_next;
    logic [ROOM_W-1:0]    room_reg, room_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [SIZE_W-1:0]    sx_reg, sx_next;
    logic [SIZE_W-1:0]    sy_reg, sy_next;
    logic [MAX_WIDTH-1:0] mask_reg, mask_next;
    logic                 placed_reg, placed_next;
    logic [XW-1:0]        px_reg, px_next;
    logic [YW-1:0]        py_reg, py_next;
    logic [ROOM_W-1:0]    num_reg, num_next;
    logic                 full_reg, full_next;

    logic [CW-1:0]        area_w;
    logic [CW-1:0]        area_h;
    logic [MAX_WIDTH-1:0] width_mask;
    logic                 accept;
    logic                 fits;
    grid_ctrl_t           grid_ctrl;
    lane_ctrl_t           lane_ctrl;
    logic [MAX_WIDTH-1:0] row;
    logic                 pick_valid;
    logic [XW-1:0]        pick_x;
    logic [YW-1:0]        pick_y;

    // Register values above the grid size saturate to it.
    assign area_w = (int'(gw_reg) > MAX_WIDTH)  ? CW'(MAX_WIDTH)  : CW'(gw_reg);
    assign area_h = (int'(gh_reg) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(gh_reg);
    assign width_mask = low_mask(area_w);

    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign fits = (req_data.size_x != '0) && (req_data.size_y != '0) &&
                  (CW'(req_data.size_x) <= area_w) && (CW'(req_data.size_y) <= area_h) &&
                  (room_reg < COUNT_MAX);

    always_comb
    begin
        state_next     = state_reg;
        gw_next        = gw_reg;
        gh_next        = gh_reg;
        room_next      = room_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        cnt_next       = cnt_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        mask_next      = mask_reg;
        placed_next    = placed_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        num_next       = num_reg;
        full_next      = full_reg;

        grid_ctrl.clear = 1'b0;
        grid_ctrl.wr    = 1'b0;
        grid_ctrl.idx   = cnt_reg[YW-1:0];
        grid_ctrl.mask  = mask_reg << px_reg;
        lane_ctrl.start = 1'b0;
        lane_ctrl.step  = 1'b0;
        lane_ctrl.row_y = cnt_reg[YW-1:0];

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_GRID_WIDTH)
            begin
                gw_next = cfg_data;
            end
            else if (cfg_index == CFG_GRID_HEIGHT)
            begin
                gh_next = cfg_data;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sx_next     = req_data.size_x;
                    sy_next     = req_data.size_y;
                    mask_next   = low_mask(CW'(req_data.size_x));
                    placed_next = 1'b0;
                    px_next     = '0;
                    py_next     = '0;
                    num_next    = '0;
                    cnt_next    = '0;
                    full_next   = 1'b1;
                    if (req_data.req_type == REQ_CLEAR)
                    begin
                        grid_ctrl.clear = 1'b1;
                        room_next       = '0;
                        state_next      = S_FULL;
                    end
                    else if (fits)
                    begin
                        lane_ctrl.start = 1'b1;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FULL;
                    end
                end
            end
            S_SCAN:
            begin
                lane_ctrl.step = 1'b1;
                if (cnt_reg + CW'(1) == area_h)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_PICK:
            begin
                cnt_next = '0;
                if (pick_valid)
                begin
                    placed_next = 1'b1;
                    px_next     = pick_x;
                    py_next     = pick_y;
                    room_next   = room_reg + ROOM_W'(1);
                    num_next    = room_reg + ROOM_W'(1);
                    state_next  = S_MARK;
                end
                else
                begin
                    state_next = S_FULL;
                end
            end
            S_MARK:
            begin
                grid_ctrl.wr  = 1'b1;
                grid_ctrl.idx = YW'(py_reg + cnt_reg[YW-1:0]);
                if (cnt_reg + CW'(1) == CW'(sy_reg))
                begin
                    cnt_next   = '0;
                    state_next = S_FULL;
                end
                else
                begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            S_FULL:
            begin
                // An empty area has no rows to check and counts as full.
                if (cnt_reg >= area_h)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if ((row & width_mask) != width_mask)
                    begin
                        full_next = 1'b0;
                    end
                    if (cnt_reg + CW'(1) == area_h)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.placed      = placed_reg;
                    rsp_next.pos_x       = POS_W'(px_reg);
                    rsp_next.pos_y       = POS_W'(py_reg);
                    rsp_next.room_number = num_reg;
                    rsp_next.grid_full   = full_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gw_reg        <= CFG_RESET;
            gh_reg        <= CFG_RESET;
            room_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
            room_reg      <= room_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg    <= rsp_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        mask_reg   <= mask_next;
        placed_reg <= placed_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        num_reg    <= num_next;
        full_reg   <= full_next;
    end

    gfa_grid u_grid (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (grid_ctrl),
        .row  (row)
    );

    gfa_lanes u_lanes (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (lane_ctrl),
        .row       (row),
        .size_mask (mask_reg),
        .size_x    (sx_reg),
        .size_y    (sy_reg),
        .area_w    (area_w),
        .pick_valid(pick_valid),
        .pick_x    (pick_x),
        .pick_y    (pick_y)
    );

endmodule
